/* rtl/psls_pkg.sv */
// ----------------------------------------------------------------------------
// psls_pkg
// Types and codes shared by the p-state linear search block.
// ----------------------------------------------------------------------------
package psls_pkg;

	typedef logic [4:0]  pstate_t;
	typedef logic [31:0] fix_t;
	typedef logic [23:0] freq_t;
	typedef logic [1:0]  cfg_index_t;
	typedef logic [5:0]  cfg_data_t;

	// register indexes
	localparam cfg_index_t REG_METRIC   = 2'd0;
	localparam cfg_index_t REG_STRATEGY = 2'd1;
	localparam cfg_index_t REG_COUNT    = 2'd2;

	// metric codes
	localparam logic [2:0] MET_CPI      = 3'd0;
	localparam logic [2:0] MET_GFLOPS   = 3'd1;
	localparam logic [2:0] MET_GFLOPS_W = 3'd2;
	localparam logic [2:0] MET_GBPS_W   = 3'd3;
	localparam logic [2:0] MET_GPU      = 3'd4;

	// strategy codes
	localparam logic [1:0] STR_MAX   = 2'd0;
	localparam logic [1:0] STR_MIN   = 2'd1;
	localparam logic [1:0] STR_RATIO = 2'd2;

	localparam logic [2:0] METRIC_RESET   = MET_CPI;
	localparam logic [1:0] STRATEGY_RESET = STR_MIN;
	localparam logic [5:0] COUNT_RESET    = 6'd32;

	typedef struct packed {
		fix_t  cpi;
		fix_t  gflops;
		fix_t  bandwidth;
		fix_t  power;
		freq_t base_freq;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_LHS,
		S_RHS,
		S_ALO,
		S_AHI,
		S_BLO,
		S_BHI,
		S_SUM,
		S_DEC
	} state_t;

endpackage

/* rtl/pstate_linear_search.sv */
// ----------------------------------------------------------------------------
// pstate_linear_search
// Per-p-state sample table with a linear search over the p-states.
// An accepted sample goes through S_RD, S_LHS and S_RHS to S_DEC for the max
// and min strategies; the ratio strategy adds S_ALO, S_AHI, S_BLO, S_BHI and
// S_SUM (one shared 32x32 multiplier works through the cross products, one per
// cycle). One sample at a time; the next word is taken in the cycle after the
// result is registered. A reset word gives no result. Asynchronous reset clears
// the control state and the per-entry valid bits; invalid entries read as zero.
// ----------------------------------------------------------------------------
module pstate_linear_search #(
	parameter int MAX_PSTATES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  psls_pkg::cfg_index_t cfg_index,
	input  psls_pkg::cfg_data_t  cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  psls_pkg::pstate_t    current_pstate,
	input  psls_pkg::fix_t       cpi_value,
	input  psls_pkg::fix_t       gflops_value,
	input  psls_pkg::fix_t       bandwidth_value,
	input  psls_pkg::fix_t       power_value,
	input  psls_pkg::freq_t      default_freq,
	output logic                 out_valid,
	input  logic                 out_stall,
	output psls_pkg::pstate_t    sel_pstate,
	output logic                 readiness
);
	import psls_pkg::*;

	localparam int PW = $clog2(MAX_PSTATES);

	logic [2:0] metric_select_q;
	logic [1:0] strategy_select_q;
	logic [5:0] pstate_count_q;

	state_t state_q, state_d;
	logic search_active_q;
	logic [MAX_PSTATES-1:0] valid_q;

	entry_t mem [MAX_PSTATES];
	entry_t rd_s1;
	logic   rd_vld_s1;
	entry_t item_s1;
	logic [PW-1:0] p_s1;

	logic [63:0] lhs_q, rhs_q, alo_q, ahi_q, blo_q, bhi_q;
	logic [95:0] asum_q, bsum_q;

	logic out_valid_q;
	pstate_t sel_pstate_q;
	logic readiness_q;

	int cnt_i, p_i;
	logic [PW-1:0] last_idx, acc_idx, prev_idx;
	logic accept, sample_acc;

	entry_t prev;
	fix_t cn, cd, pn, pd;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic improved;
	logic [PW-1:0] next_idx;
	logic rdy_d, act_d, out_free;

	assign accept     = in_valid && !in_stall;
	assign sample_acc = accept && !kind;
	assign in_stall   = (state_q != S_IDLE);
	assign out_free   = !(out_valid_q && out_stall);

	assign out_valid  = out_valid_q;
	assign sel_pstate = sel_pstate_q;
	assign readiness  = readiness_q;

	// count clamp and p-state saturation
	always_comb begin
		cnt_i = int'(pstate_count_q);
		if (cnt_i < 1) cnt_i = 1;
		if (cnt_i > MAX_PSTATES) cnt_i = MAX_PSTATES;
		last_idx = PW'(cnt_i - 1);
		p_i = int'(current_pstate);
		if (p_i > cnt_i - 1) p_i = cnt_i - 1;
		acc_idx = PW'(p_i);
		prev_idx = (acc_idx == '0) ? '0 : acc_idx - PW'(1);
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_select_q   <= METRIC_RESET;
			strategy_select_q <= STRATEGY_RESET;
			pstate_count_q    <= COUNT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_METRIC:   metric_select_q   <= cfg_data[2:0];
				REG_STRATEGY: strategy_select_q <= cfg_data[1:0];
				REG_COUNT:    pstate_count_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample table
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			mem[acc_idx] <= '{cpi: cpi_value, gflops: gflops_value,
				bandwidth: bandwidth_value, power: power_value, base_freq: default_freq};
			rd_s1   <= mem[prev_idx];
			item_s1 <= '{cpi: cpi_value, gflops: gflops_value,
				bandwidth: bandwidth_value, power: power_value, base_freq: default_freq};
			p_s1    <= acc_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (sample_acc) begin
			valid_q[acc_idx] <= 1'b1;
			rd_vld_s1        <= valid_q[prev_idx];
		end
	end

	// metric fractions
	always_comb begin
		prev = rd_vld_s1 ? rd_s1 : '0;
		cd = 32'd1;
		pd = 32'd1;
		case (metric_select_q)
			MET_CPI: begin
				cn = item_s1.cpi;
				pn = prev.cpi;
			end
			MET_GFLOPS: begin
				cn = item_s1.gflops;
				pn = prev.gflops;
			end
			MET_GFLOPS_W: begin
				cn = item_s1.gflops;
				pn = prev.gflops;
				cd = item_s1.power;
				pd = prev.power;
			end
			default: begin
				cn = item_s1.bandwidth;
				pn = prev.bandwidth;
				cd = item_s1.power;
				pd = prev.power;
			end
		endcase
	end

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_LHS: begin
				mul_a = cn;
				mul_b = pd;
			end
			S_RHS: begin
				mul_a = pn;
				mul_b = cd;
			end
			S_ALO: begin
				mul_a = lhs_q[31:0];
				mul_b = {8'd0, prev.base_freq};
			end
			S_AHI: begin
				mul_a = lhs_q[63:32];
				mul_b = {8'd0, prev.base_freq};
			end
			S_BLO: begin
				mul_a = rhs_q[31:0];
				mul_b = {8'd0, item_s1.base_freq};
			end
			S_BHI: begin
				mul_a = rhs_q[63:32];
				mul_b = {8'd0, item_s1.base_freq};
			end
			default: ;
		endcase
		mul_p = {32'd0, mul_a} * {32'd0, mul_b};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LHS: lhs_q <= mul_p;
			S_RHS: rhs_q <= mul_p;
			S_ALO: alo_q <= mul_p;
			S_AHI: ahi_q <= mul_p;
			S_BLO: blo_q <= mul_p;
			S_BHI: bhi_q <= mul_p;
			S_SUM: begin
				asum_q <= {ahi_q, 32'd0} + {32'd0, alo_q};
				bsum_q <= {bhi_q, 32'd0} + {32'd0, blo_q};
			end
			default: ;
		endcase
	end

	// search decision
	always_comb begin
		improved = 1'b0;
		if (metric_select_q < MET_GPU && cd != '0 && pd != '0) begin
			case (strategy_select_q)
				STR_MAX:   improved = (lhs_q > rhs_q);
				STR_MIN:   improved = (lhs_q < rhs_q);
				STR_RATIO: improved = (pn != '0) && (prev.base_freq != '0) && (asum_q < bsum_q);
				default:   improved = 1'b0;
			endcase
		end
		if (search_active_q && p_s1 == '0) begin
			next_idx = '0;
			rdy_d    = 1'b1;
			act_d    = 1'b0;
		end else if (!search_active_q || improved) begin
			act_d = 1'b1;
			if (p_s1 < last_idx) begin
				next_idx = p_s1 + PW'(1);
				rdy_d    = 1'b0;
			end else begin
				next_idx = p_s1;
				rdy_d    = 1'b1;
			end
		end else begin
			next_idx = p_s1 - PW'(1);
			rdy_d    = 1'b1;
			act_d    = 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (sample_acc) state_d = S_RD;
			S_RD:   state_d = S_LHS;
			S_LHS:  state_d = S_RHS;
			S_RHS:  state_d = (strategy_select_q == STR_RATIO) ? S_ALO : S_DEC;
			S_ALO:  state_d = S_AHI;
			S_AHI:  state_d = S_BLO;
			S_BLO:  state_d = S_BHI;
			S_BHI:  state_d = S_SUM;
			S_SUM:  state_d = S_DEC;
			S_DEC:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// search phase and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_active_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else if (state_q == S_DEC && out_free) begin
			search_active_q <= act_d;
			out_valid_q     <= 1'b1;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (accept && kind) search_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DEC && out_free) begin
			sel_pstate_q <= 5'(next_idx);
			readiness_q  <= rdy_d;
		end
	end

endmodule
